// ===== rtl/core/ddd_pacemaker_timing_controller_core_defines.svh =====
// assertion macros for the pacemaker core
`ifndef DDD_PACEMAKER_TIMING_CONTROLLER_CORE_DEFINES_SVH
`define DDD_PACEMAKER_TIMING_CONTROLLER_CORE_DEFINES_SVH

// checked only outside reset
`define DDD_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define DDD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/ddd_pkg.sv =====
package ddd_pkg;

   localparam int NTIMERS = 6;
   localparam int NFLAGS  = 33;
   localparam int CFG_W   = 12;
   localparam int CSR_IDX_W = 3;

   // timer slots, also the bit order of the command vectors
   localparam int T_AVI   = 0;
   localparam int T_AEI   = 1;
   localparam int T_PVARP = 2;
   localparam int T_VRP   = 3;
   localparam int T_LRI   = 4;
   localparam int T_URI   = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AVI   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AEI   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PVARP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VRP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LRI   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_URI   = 3'd5;

   localparam logic [NTIMERS-1:0][CFG_W-1:0] CFG_RESET = {
      12'd900, 12'd950, 12'd150, 12'd50, 12'd800, 12'd300
   };

   typedef struct packed {
      logic [NTIMERS-1:0] start;
      logic [NTIMERS-1:0] stop;
   } timer_cmd_type;

   typedef struct packed {
      logic               vpace;
      logic               apace;
      logic [NTIMERS-1:0] timer_start;
      logic [NTIMERS-1:0] timer_stop;
      logic [NTIMERS-1:0] timer_expired;
   } result_type;

endpackage

// ===== rtl/core/ddd_timer_bank.sv =====
`include "ddd_pacemaker_timing_controller_core_defines.svh"

module ddd_timer_bank #(
   parameter int TIMER_BITS = 12
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          step,
   input  logic                                          tick,
   input  ddd_pkg::timer_cmd_type                        cmd,
   input  logic [ddd_pkg::NTIMERS-1:0][ddd_pkg::CFG_W-1:0] cfg,
   output logic [ddd_pkg::NTIMERS-1:0]                   expired
);

   localparam int N = ddd_pkg::NTIMERS;

   logic [N-1:0][TIMER_BITS+ddd_pkg::CFG_W-1:0] cfg_ext;
   logic [N-1:0][TIMER_BITS-1:0] load_val;
   logic [N-1:0][TIMER_BITS-1:0] rem_ff, rem_in;
   logic [N-1:0] run_ff, run_in;
   logic [N-1:0] loaded;

   always_comb begin
      for (int i = 0; i < N; i++) begin
         cfg_ext[i]  = {{TIMER_BITS{1'b0}}, cfg[i]};
         load_val[i] = cfg_ext[i][TIMER_BITS-1:0];
         run_in[i]   = run_ff[i];
         rem_in[i]   = rem_ff[i];
         loaded[i]   = 1'b0;
         expired[i]  = 1'b0;
         // stop wins over start
         if (cmd.stop[i]) begin
            run_in[i] = 1'b0;
            rem_in[i] = '0;
         end else if (cmd.start[i]) begin
            run_in[i] = 1'b1;
            rem_in[i] = load_val[i];
            loaded[i] = 1'b1;
         end
         if (tick && run_in[i] && !loaded[i]) begin
            if (rem_in[i] <= TIMER_BITS'(1)) begin
               rem_in[i]  = '0;
               run_in[i]  = 1'b0;
               expired[i] = 1'b1;
            end else begin
               rem_in[i] = rem_in[i] - TIMER_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
         rem_ff <= '0;
      end else if (step) begin
         run_ff <= run_in;
         rem_ff <= rem_in;
      end
   end

   `DDD_ASSERT_CLK(a_expire_needs_tick, (|expired) |-> tick, "expiry without a tick")
   `DDD_ASSERT_CLK(a_expire_not_commanded, (|(expired & (cmd.start | cmd.stop))) == 1'b0,
      "commanded timer expired")

endmodule

// ===== rtl/core/ddd_react_net.sv =====
module ddd_react_net (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          vs,
   input  logic                          as,
   input  logic [ddd_pkg::NTIMERS-1:0]   expired,
   output ddd_pkg::timer_cmd_type        cmd,
   output ddd_pkg::result_type           result
);

   logic [ddd_pkg::NFLAGS-1:0] flags_ff, flags_in;
   logic first_ff;
   ddd_pkg::timer_cmd_type cmd_ff, cmd_in;

   always_comb begin
      logic [ddd_pkg::NFLAGS-1:0] p;
      logic [ddd_pkg::NFLAGS-1:0] n;
      logic [ddd_pkg::NTIMERS-1:0] st, sp;
      logic go, vp, ap;
      logic x_avi, x_aei, x_pvarp, x_vrp, x_lri, x_uri;
      logic a, b, c, d, e, f, h, k, m, q, r, s, t, u, w;
      p = flags_ff;
      go = first_ff;
      st = '0;
      sp = '0;
      x_avi   = expired[ddd_pkg::T_AVI];
      x_aei   = expired[ddd_pkg::T_AEI];
      x_pvarp = expired[ddd_pkg::T_PVARP];
      x_vrp   = expired[ddd_pkg::T_VRP];
      x_lri   = expired[ddd_pkg::T_LRI];
      x_uri   = expired[ddd_pkg::T_URI];
      ap = 1'b0;
      vp = (p[19] & x_uri) | (p[20] & x_avi);

      // ventricular escape
      a = p[0] & ~vs;
      n[0] = go | (a & ~vp);
      st[ddd_pkg::T_LRI] = (p[0] & vs) | (a & vp) | p[3];
      n[1] = (p[1] & ~x_vrp) | (a & vp) | (p[0] & vs) | p[3];
      b = p[2] & ~vs;
      c = b & ~vp;
      n[2] = (p[1] & x_vrp) | (c & ~x_lri);
      sp[ddd_pkg::T_LRI] = (p[2] & vs) | (b & vp);
      vp = vp | (c & x_lri);
      n[3] = (b & vp) | (c & x_lri) | (p[2] & vs);

      // upper rate
      d = p[4] & ~vs;
      e = p[7] & ~vs;
      sp[ddd_pkg::T_URI] = (p[5] & x_uri) | (p[6] & x_uri) | (e & x_uri);
      n[4] = go | (d & ~vp) | (p[5] & x_uri) | (p[6] & x_uri) | (e & x_uri);
      f = p[5] & ~x_uri;
      h = f & ~x_pvarp;
      st[ddd_pkg::T_URI] = (p[4] & vs) | (d & vp) | p[8];
      n[5] = (p[4] & vs) | (h & ~x_vrp) | (d & vp) | p[8];
      k = p[6] & ~x_uri;
      m = k & ~x_vrp;
      n[6] = (f & x_pvarp) | (m & ~x_pvarp) | (h & x_vrp);
      sp[ddd_pkg::T_URI] = sp[ddd_pkg::T_URI] | (k & x_vrp) | (m & x_pvarp);
      n[7] = (e & ~x_uri) | (k & x_vrp) | (m & x_pvarp);
      sp[ddd_pkg::T_URI] = sp[ddd_pkg::T_URI] | (p[7] & vs);
      n[8] = p[7] & vs;

      // lri and uri mirrors
      q = p[10] & ~sp[ddd_pkg::T_LRI];
      n[9] = (p[10] & sp[ddd_pkg::T_LRI]) | (q & x_lri) | go | (p[9] & ~st[ddd_pkg::T_LRI]);
      n[10] = (p[9] & st[ddd_pkg::T_LRI]) | (q & ~x_lri);
      q = p[12] & ~sp[ddd_pkg::T_URI];
      n[11] = (p[12] & sp[ddd_pkg::T_URI]) | (q & x_uri) | go | (p[11] & ~st[ddd_pkg::T_URI]);
      n[12] = (p[11] & st[ddd_pkg::T_URI]) | (q & ~x_uri);

      // ventricular refractory
      r = p[13] & ~vp;
      n[13] = (p[14] & x_vrp) | (r & ~vs) | go;
      st[ddd_pkg::T_VRP] = (p[13] & vp) | (r & vs);
      n[14] = (p[14] & ~x_vrp) | (r & vs) | (p[13] & vp);
      s = p[16] & ~x_vrp;
      n[15] = go | (p[15] & ~st[ddd_pkg::T_VRP]) | (p[16] & x_vrp) | (s & sp[ddd_pkg::T_VRP]);
      n[16] = (p[15] & st[ddd_pkg::T_VRP]) | (s & ~sp[ddd_pkg::T_VRP]);

      // atrioventricular
      t = p[20] & ~x_avi;
      u = t & ~vs;
      sp[ddd_pkg::T_AVI] = (t & vs) | (u & vp) | (p[18] & vs);
      w = p[25] & ~as;
      ap = w & x_aei;
      a = p[17] & ~as;
      b = p[19] & ~x_uri;
      c = b & ~vs;
      d = p[18] & ~vs;
      sp[ddd_pkg::T_AVI] = sp[ddd_pkg::T_AVI] | (c & vp) | (d & vp) | (b & vs);
      n[17] = go | (t & vs) | (u & vp) | (p[18] & vs) | (p[19] & x_uri) | (a & ~ap)
            | (c & vp) | (p[20] & x_avi) | (d & vp) | (b & vs);
      st[ddd_pkg::T_AVI] = (p[17] & as) | (a & ap);
      e = d & ~vp;
      f = e & ~x_avi;
      n[18] = (a & ap) | (f & ~x_uri) | (p[17] & as);
      n[19] = (e & x_avi) | (c & ~vp);
      n[20] = (f & x_uri) | (u & ~vp);
      h = p[22] & ~x_avi;
      n[21] = (h & sp[ddd_pkg::T_AVI]) | go | (p[22] & x_avi) | (p[21] & ~st[ddd_pkg::T_AVI]);
      n[22] = (p[21] & st[ddd_pkg::T_AVI]) | (h & ~sp[ddd_pkg::T_AVI]);

      // atrial escape
      k = p[23] & ~vs;
      sp[ddd_pkg::T_AEI] = p[25] & as;
      n[23] = go | (w & x_aei) | (k & ~vp) | (p[25] & as);
      st[ddd_pkg::T_AEI] = (p[23] & vs) | (k & vp);
      n[24] = (p[23] & vs) | (k & vp) | (p[24] & ~x_pvarp);
      n[25] = (p[24] & x_pvarp) | (w & ~x_aei);
      m = p[27] & ~x_aei;
      n[26] = (p[27] & x_aei) | (p[26] & ~st[ddd_pkg::T_AEI]) | (m & sp[ddd_pkg::T_AEI]) | go;
      n[27] = (p[26] & st[ddd_pkg::T_AEI]) | (m & ~sp[ddd_pkg::T_AEI]);

      // post ventricular atrial refractory
      q = p[28] & ~vs;
      n[28] = (p[29] & x_pvarp) | go | (q & ~vp);
      st[ddd_pkg::T_PVARP] = (p[28] & vs) | (q & vp);
      n[29] = (p[29] & ~x_pvarp) | (q & vp) | (p[28] & vs);
      r = p[31] & ~x_pvarp;
      n[30] = (p[31] & x_pvarp) | go | (r & sp[ddd_pkg::T_PVARP])
            | (p[30] & ~st[ddd_pkg::T_PVARP]);
      n[31] = (p[30] & st[ddd_pkg::T_PVARP]) | (r & ~sp[ddd_pkg::T_PVARP]);

      n[32] = p[32] | go;

      flags_in = n;
      cmd_in.start = st;
      cmd_in.stop = sp;
      result.vpace = vp;
      result.apace = ap;
      result.timer_start = st;
      result.timer_stop = sp;
      result.timer_expired = expired;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         first_ff <= 1'b1;
         cmd_ff   <= '0;
      end else if (step) begin
         flags_ff <= flags_in;
         first_ff <= 1'b0;
         cmd_ff   <= cmd_in;
      end
   end

   assign cmd = cmd_ff;

endmodule

// ===== rtl/core/ddd_pacemaker_timing_controller_core.sv =====
// DDD pacemaker reaction engine. Each request is one reaction: sensed atrial
// and ventricular beats plus a millisecond tick. The core accepts one request
// per clock and presents exactly one result per request, through the request
// register and then the result register, as long as the result side keeps
// up. The reaction network and the six countdown timers evaluate together,
// combinationally, between the two registers. Timer intervals come from six
// 12-bit registers written over the csr port; the user must write them only
// while the core is idle, the core itself does not enforce this. There is no
// read-back and no clearing pass after reset. TIMER_BITS sets the countdown
// width; register values wider than that are truncated on load.
`include "ddd_pacemaker_timing_controller_core_defines.svh"

module ddd_pacemaker_timing_controller_core #(
   parameter int TIMER_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_vsense,
   input  logic                             req_asense,
   input  logic                             req_ms_tick,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_vpace,
   output logic                             rsp_apace,
   output logic [ddd_pkg::NTIMERS-1:0]      rsp_timer_start,
   output logic [ddd_pkg::NTIMERS-1:0]      rsp_timer_stop,
   output logic [ddd_pkg::NTIMERS-1:0]      rsp_timer_expired,
   input  logic                             csr_we,
   input  logic [ddd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ddd_pkg::CFG_W-1:0]        csr_wdata
);

   logic [ddd_pkg::NTIMERS-1:0][ddd_pkg::CFG_W-1:0] cfg_ff;
   logic in_valid_ff, in_valid_in;
   logic vs_ff, as_ff, tick_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic step;
   logic [ddd_pkg::NTIMERS-1:0] expired;
   ddd_pkg::timer_cmd_type cmd;
   ddd_pkg::result_type result;
   ddd_pkg::result_type result_ff;

   // interval registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ddd_pkg::CFG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ddd_pkg::CSR_AVI:   cfg_ff[ddd_pkg::T_AVI]   <= csr_wdata;
            ddd_pkg::CSR_AEI:   cfg_ff[ddd_pkg::T_AEI]   <= csr_wdata;
            ddd_pkg::CSR_PVARP: cfg_ff[ddd_pkg::T_PVARP] <= csr_wdata;
            ddd_pkg::CSR_VRP:   cfg_ff[ddd_pkg::T_VRP]   <= csr_wdata;
            ddd_pkg::CSR_LRI:   cfg_ff[ddd_pkg::T_LRI]   <= csr_wdata;
            ddd_pkg::CSR_URI:   cfg_ff[ddd_pkg::T_URI]   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign step = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         vs_ff   <= req_vsense;
         as_ff   <= req_asense;
         tick_ff <= req_ms_tick;
      end
      if (step) begin
         result_ff <= result;
      end
   end

   ddd_timer_bank #(
      .TIMER_BITS(TIMER_BITS)
   ) u_timers (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .tick   (tick_ff),
      .cmd    (cmd),
      .cfg    (cfg_ff),
      .expired(expired)
   );

   ddd_react_net u_net (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .vs     (vs_ff),
      .as     (as_ff),
      .expired(expired),
      .cmd    (cmd),
      .result (result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_vpace         = result_ff.vpace;
   assign rsp_apace         = result_ff.apace;
   assign rsp_timer_start   = result_ff.timer_start;
   assign rsp_timer_stop    = result_ff.timer_stop;
   assign rsp_timer_expired = result_ff.timer_expired;

   `DDD_ASSERT_CLK(a_stall_means_full, !req_ready |-> (in_valid_ff && rsp_valid_ff),
      "request side stalled with a free stage")
   `DDD_ASSERT_CLK(a_rsp_from_step, $rose(rsp_valid_ff) |-> $past(step),
      "result appeared without a reaction")

endmodule

// ===== sim/tb_ddd_pacemaker_timing_controller_core.sv =====
module tb_ddd_pacemaker_timing_controller_core;

   localparam int NTIMERS   = ddd_pkg::NTIMERS;
   localparam int NFLAGS    = ddd_pkg::NFLAGS;
   localparam int CFG_W     = ddd_pkg::CFG_W;
   localparam int CSR_IDX_W = ddd_pkg::CSR_IDX_W;
   localparam int T_AVI     = ddd_pkg::T_AVI;
   localparam int T_AEI     = ddd_pkg::T_AEI;
   localparam int T_PVARP   = ddd_pkg::T_PVARP;
   localparam int T_VRP     = ddd_pkg::T_VRP;
   localparam int T_LRI     = ddd_pkg::T_LRI;
   localparam int T_URI     = ddd_pkg::T_URI;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int PHASES = 8;
   localparam int PHASE_REACTIONS = 106;
   localparam int SCRIPT_ROWS = 24;

   typedef struct {
      bit                  vs;
      bit                  as;
      bit                  tk;
      bit                  reprogram;
      bit                  typed;
      ddd_pkg::result_type want;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_vsense;
   logic                 req_asense;
   logic                 req_ms_tick;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_vpace;
   logic                 rsp_apace;
   logic [NTIMERS-1:0]   rsp_timer_start;
   logic [NTIMERS-1:0]   rsp_timer_stop;
   logic [NTIMERS-1:0]   rsp_timer_expired;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   // predictor state
   bit [NFLAGS-1:0]  net;
   bit               fresh;
   bit [CFG_W-1:0]   tmr_left [NTIMERS];
   bit               tmr_on [NTIMERS];
   bit [NTIMERS-1:0] cmd_start;
   bit [NTIMERS-1:0] cmd_stop;
   bit [CFG_W-1:0]   interval [NTIMERS];

   ddd_pkg::result_type expected_reactions [$];
   ddd_pkg::result_type oldest;
   int                  mismatches = 0;
   bit                  steady = 1'b0;

   stim_row_type script [SCRIPT_ROWS] = '{
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, {2'b00, 6'd0, 6'd0, 6'd0}},
      '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, {2'b00, 6'd62, 6'd0, 6'd0}},
      '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, '0},
      '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0}
   };

   ddd_pacemaker_timing_controller_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_vsense        (req_vsense),
      .req_asense        (req_asense),
      .req_ms_tick       (req_ms_tick),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_vpace         (rsp_vpace),
      .rsp_apace         (rsp_apace),
      .rsp_timer_start   (rsp_timer_start),
      .rsp_timer_stop    (rsp_timer_stop),
      .rsp_timer_expired (rsp_timer_expired),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2400000;
      $display("tb: failure");
      $finish;
   end

   function automatic ddd_pkg::result_type react(input bit vs, input bit as, input bit tk);
      bit [NFLAGS-1:0]     p;
      bit [NFLAGS-1:0]     n;
      bit [NTIMERS-1:0]    ex;
      bit [NTIMERS-1:0]    st;
      bit [NTIMERS-1:0]    sp;
      bit                  go;
      bit                  vp;
      bit                  ap;
      bit                  ld;
      bit                  xa, xe, xp, xv, xl, xu;
      bit                  a, b, c, d, e, f, h, k, m, q, r, s, t, u, w;
      ddd_pkg::result_type res;
      p = net;
      n = '0;
      go = fresh;
      ex = '0;
      st = '0;
      sp = '0;
      vp = 1'b0;
      ap = 1'b0;

      // pending commands first, stop wins, then the countdown
      for (int i = 0; i < NTIMERS; i++) begin
         ld = 1'b0;
         if (cmd_stop[i]) begin
            tmr_on[i] = 1'b0;
            tmr_left[i] = '0;
         end else if (cmd_start[i]) begin
            tmr_on[i] = 1'b1;
            tmr_left[i] = interval[i];
            ld = 1'b1;
         end
         if (tk && tmr_on[i] && !ld) begin
            if (tmr_left[i] <= 1) begin
               tmr_left[i] = '0;
               tmr_on[i] = 1'b0;
               ex[i] = 1'b1;
            end else begin
               tmr_left[i] = tmr_left[i] - 1'b1;
            end
         end
      end
      xa = ex[T_AVI];
      xe = ex[T_AEI];
      xp = ex[T_PVARP];
      xv = ex[T_VRP];
      xl = ex[T_LRI];
      xu = ex[T_URI];

      vp |= (p[19] && xu) || (p[20] && xa);

      // ventricular escape
      a = p[0] && !vs;
      n[0] = go || (a && !vp);
      st[T_LRI] |= (p[0] && vs) || (a && vp) || p[3];
      n[1] = (p[1] && !xv) || (a && vp) || (p[0] && vs) || p[3];
      b = p[2] && !vs;
      c = b && !vp;
      n[2] = (p[1] && xv) || (c && !xl);
      sp[T_LRI] |= (p[2] && vs) || (b && vp);
      vp |= c && xl;
      n[3] = (b && vp) || (c && xl) || (p[2] && vs);

      // upper rate
      d = p[4] && !vs;
      e = p[7] && !vs;
      sp[T_URI] |= (p[5] && xu) || (p[6] && xu) || (e && xu);
      n[4] = go || (d && !vp) || (p[5] && xu) || (p[6] && xu) || (e && xu);
      f = p[5] && !xu;
      h = f && !xp;
      st[T_URI] |= (p[4] && vs) || (d && vp) || p[8];
      n[5] = (p[4] && vs) || (h && !xv) || (d && vp) || p[8];
      k = p[6] && !xu;
      m = k && !xv;
      n[6] = (f && xp) || (m && !xp) || (h && xv);
      sp[T_URI] |= (k && xv) || (m && xp);
      n[7] = (e && !xu) || (k && xv) || (m && xp);
      sp[T_URI] |= p[7] && vs;
      n[8] = p[7] && vs;

      // lri and uri mirrors
      q = p[10] && !sp[T_LRI];
      n[9] = (p[10] && sp[T_LRI]) || (q && xl) || go || (p[9] && !st[T_LRI]);
      n[10] = (p[9] && st[T_LRI]) || (q && !xl);
      q = p[12] && !sp[T_URI];
      n[11] = (p[12] && sp[T_URI]) || (q && xu) || go || (p[11] && !st[T_URI]);
      n[12] = (p[11] && st[T_URI]) || (q && !xu);

      // ventricular refractory
      r = p[13] && !vp;
      n[13] = (p[14] && xv) || (r && !vs) || go;
      st[T_VRP] |= (p[13] && vp) || (r && vs);
      n[14] = (p[14] && !xv) || (r && vs) || (p[13] && vp);
      s = p[16] && !xv;
      n[15] = go || (p[15] && !st[T_VRP]) || (p[16] && xv) || (s && sp[T_VRP]);
      n[16] = (p[15] && st[T_VRP]) || (s && !sp[T_VRP]);

      // atrioventricular
      t = p[20] && !xa;
      u = t && !vs;
      sp[T_AVI] |= (t && vs) || (u && vp) || (p[18] && vs);
      w = p[25] && !as;
      ap |= w && xe;
      a = p[17] && !as;
      b = p[19] && !xu;
      c = b && !vs;
      d = p[18] && !vs;
      sp[T_AVI] |= (c && vp) || (d && vp) || (b && vs);
      n[17] = go || (t && vs) || (u && vp) || (p[18] && vs) || (p[19] && xu) ||
              (a && !ap) || (c && vp) || (p[20] && xa) || (d && vp) || (b && vs);
      st[T_AVI] |= (p[17] && as) || (a && ap);
      e = d && !vp;
      f = e && !xa;
      n[18] = (a && ap) || (f && !xu) || (p[17] && as);
      n[19] = (e && xa) || (c && !vp);
      n[20] = (f && xu) || (u && !vp);
      h = p[22] && !xa;
      n[21] = (h && sp[T_AVI]) || go || (p[22] && xa) || (p[21] && !st[T_AVI]);
      n[22] = (p[21] && st[T_AVI]) || (h && !sp[T_AVI]);

      // atrial escape
      k = p[23] && !vs;
      sp[T_AEI] |= p[25] && as;
      n[23] = go || (w && xe) || (k && !vp) || (p[25] && as);
      st[T_AEI] |= (p[23] && vs) || (k && vp);
      n[24] = (p[23] && vs) || (k && vp) || (p[24] && !xp);
      n[25] = (p[24] && xp) || (w && !xe);
      m = p[27] && !xe;
      n[26] = (p[27] && xe) || (p[26] && !st[T_AEI]) || (m && sp[T_AEI]) || go;
      n[27] = (p[26] && st[T_AEI]) || (m && !sp[T_AEI]);

      // post ventricular atrial refractory
      q = p[28] && !vs;
      n[28] = (p[29] && xp) || go || (q && !vp);
      st[T_PVARP] |= (p[28] && vs) || (q && vp);
      n[29] = (p[29] && !xp) || (q && vp) || (p[28] && vs);
      r = p[31] && !xp;
      n[30] = (p[31] && xp) || go || (r && sp[T_PVARP]) || (p[30] && !st[T_PVARP]);
      n[31] = (p[30] && st[T_PVARP]) || (r && !sp[T_PVARP]);

      n[32] = p[32] || go;

      net = n;
      fresh = 1'b0;
      cmd_start = st;
      cmd_stop = sp;
      res.vpace = vp;
      res.apace = ap;
      res.timer_start = st;
      res.timer_stop = sp;
      res.timer_expired = ex;
      return res;
   endfunction

   task automatic send_reaction(input bit vs, input bit as, input bit tk,
                                input bit typed, input ddd_pkg::result_type want);
      ddd_pkg::result_type predicted;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_vsense <= vs;
      req_asense <= as;
      req_ms_tick <= tk;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = react(vs, as, tk);
      expected_reactions.push_back(typed ? want : predicted);
   endtask

   task automatic settle();
      int waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reactions.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_reactions.size() != 0) begin
         $display("%0t: results outstanding expected 0 actual %0d", $time,
                  expected_reactions.size());
         mismatches++;
         expected_reactions.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx < NTIMERS) interval[idx] = val;
   endtask

   task automatic program_intervals(input logic [CFG_W-1:0] v [NTIMERS]);
      write_reg(CSR_SPARE_LO, CFG_W'($urandom_range(0, 4095)));
      write_reg(ddd_pkg::CSR_AVI, v[T_AVI]);
      write_reg(ddd_pkg::CSR_AEI, v[T_AEI]);
      write_reg(ddd_pkg::CSR_PVARP, v[T_PVARP]);
      write_reg(ddd_pkg::CSR_VRP, v[T_VRP]);
      write_reg(ddd_pkg::CSR_LRI, v[T_LRI]);
      write_reg(ddd_pkg::CSR_URI, v[T_URI]);
      write_reg(CSR_SPARE_HI, CFG_W'($urandom_range(0, 4095)));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 8);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reactions.size() == 0) begin
            $display("%0t: unexpected result expected none actual %b", $time,
                     {rsp_vpace, rsp_apace, rsp_timer_start, rsp_timer_stop,
                      rsp_timer_expired});
            mismatches++;
         end else begin
            oldest = expected_reactions.pop_front();
            check_field("vpace", oldest.vpace, rsp_vpace);
            check_field("apace", oldest.apace, rsp_apace);
            check_field("timer_start", oldest.timer_start, rsp_timer_start);
            check_field("timer_stop", oldest.timer_stop, rsp_timer_stop);
            check_field("timer_expired", oldest.timer_expired, rsp_timer_expired);
         end
      end
   end

   initial begin
      logic [CFG_W-1:0] setting [NTIMERS];
      int               phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_vsense = 1'b0;
      req_asense = 1'b0;
      req_ms_tick = 1'b0;
      csr_we = 1'b0;
      csr_index = ddd_pkg::CSR_AVI;
      csr_wdata = '0;
      net = '0;
      fresh = 1'b1;
      cmd_start = '0;
      cmd_stop = '0;
      for (int i = 0; i < NTIMERS; i++) begin
         tmr_left[i] = '0;
         tmr_on[i] = 1'b0;
         interval[i] = ddd_pkg::CFG_RESET[i];
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         if (script[i].reprogram) begin
            settle();
            setting = '{12'd2, 12'd3, 12'd1, 12'd2, 12'd6, 12'd4};
            program_intervals(setting);
         end
         send_reaction(script[i].vs, script[i].as, script[i].tk, script[i].typed,
                       script[i].want);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         for (int i = 0; i < NTIMERS; i++) begin
            case (phase)
               0: setting[i] = 12'd1;
               2: setting[i] = 12'd4095;
               4: setting[i] = 12'd0;
               5: begin
                  case ($urandom_range(0, 3))
                     0: setting[i] = 12'd0;
                     1: setting[i] = 12'd1;
                     2: setting[i] = 12'd4095;
                     default: setting[i] = CFG_W'($urandom_range(2, 9));
                  endcase
               end
               7: setting[i] = ddd_pkg::CFG_RESET[i];
               default: setting[i] = CFG_W'($urandom_range(1, 12));
            endcase
         end
         steady = (phase == 3);
         program_intervals(setting);
         repeat (PHASE_REACTIONS) begin
            send_reaction($urandom_range(0, 99) < 15, $urandom_range(0, 99) < 15,
                          $urandom_range(0, 99) < 75, 1'b0, '0);
         end
      end
      steady = 1'b0;
      settle();

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
